// ===== rtl/core/brhs_pkg.sv =====
// brhs_pkg: shared constants for the byte ring with header search
// request codes, status codes and fixed field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package brhs_pkg;

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_READ   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_HDR_SMALL  = 3'd1;
    localparam logic [2:0] ST_HDR_LARGE  = 3'd2;
    localparam logic [2:0] ST_NEVER_PUSH = 3'd3;
    localparam logic [2:0] ST_FEW_BYTES  = 3'd4;
    localparam logic [2:0] ST_LEN_OFS    = 3'd5;
    localparam logic [2:0] ST_LEN_WIDTH  = 3'd6;
    localparam logic [2:0] ST_EMPTY      = 3'd7;

    localparam logic [1:0] CFG_HDR_BYTES = 2'd0;
    localparam logic [1:0] CFG_HDR_SIZE  = 2'd1;
    localparam logic [1:0] CFG_LEN_OFS   = 2'd2;
    localparam logic [1:0] CFG_LEN_WIDTH = 2'd3;

    localparam int HDR_MAX     = 5;
    localparam int HDR_BITS    = 40;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

endpackage
`default_nettype wire

// ===== rtl/core/brhs_ring_mem.sv =====
// brhs_ring_mem: byte store of the ring, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module brhs_ring_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/byte_ring_with_header_search.sv =====
// byte_ring_with_header_search: top level, request sequencer and found-header table
// depends on brhs_pkg and brhs_ring_mem
`timescale 1ns / 1ps
`default_nettype none
// Byte ring of DEPTH bytes that overwrites its oldest byte when full, with a header
// search that fills a table of up to MAX_FOUND match positions. Every transaction in
// gives one transaction out. All ring reads share the single read port of the ring
// memory, one byte per cycle, under one sequencer, and the block takes one request at a
// time. Push, read-entry and unknown requests go straight to their result; pop first
// reads the head byte, clear zeroes the whole ring, and a search compares the header
// at each start offset, then reads the length field of the last match. After reset a
// clearing pass zeroes the ring before the first request is taken; configuration
// writes are taken at any time.
module byte_ring_with_header_search
    import brhs_pkg::*;
#(
    parameter int DEPTH     = 256,
    parameter int MAX_FOUND = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // byte_in[7:0], entry_index[10:8], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // ok[0], byte_out[8:1], status[11:9], found_count[15:12], entry_position[23:16],
    // entry_distance[39:24], heavy[40], stored_count[49:41], zero pad
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    input  wire logic                   cfg_wr_en,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [HDR_BITS-1:0]    cfg_data
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int FCW = $clog2(MAX_FOUND + 1);
    localparam int FIW = (MAX_FOUND > 1) ? $clog2(MAX_FOUND) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_POP  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_SCMP = 4'd5;
    localparam logic [3:0] S_LEN0 = 4'd6;
    localparam logic [3:0] S_LEN1 = 4'd7;
    localparam logic [3:0] S_LEN2 = 4'd8;
    localparam logic [3:0] S_NEED = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    function automatic logic [AW-1:0] wrap(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= (CW+1)'(DEPTH)) begin
            t = t - (CW+1)'(DEPTH);
        end
        return AW'(t);
    endfunction

    logic [HDR_BITS-1:0] hdr_reg;
    logic [2:0]          hsize_reg;
    logic [2:0]          lofs_reg;
    logic [1:0]          lwid_reg;

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                never_reg, never_next;
    logic [FCW-1:0]      found_reg, found_next;
    logic                heavy_reg, heavy_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                clr_req_reg, clr_req_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [2:0]          hidx_reg, hidx_next;
    logic [AW-1:0]       last_pos_reg, last_pos_next;
    logic [7:0]          len_lo_reg, len_lo_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    logic [AW-1:0]       pos_tab_reg [MAX_FOUND];
    logic [AW-1:0]       pos_tab_next [MAX_FOUND];
    logic [15:0]         dist_tab_reg [MAX_FOUND];
    logic [15:0]         dist_tab_next [MAX_FOUND];

    logic                res_ok_reg, res_ok_next;
    logic [7:0]          res_byte_reg, res_byte_next;
    logic [2:0]          res_stat_reg, res_stat_next;
    logic [7:0]          res_pos_reg, res_pos_next;
    logic [15:0]         res_dist_reg, res_dist_next;

    logic                      m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]    m_data_reg, m_data_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic          accept;
    logic [2:0]    req;
    logic [7:0]    byte_in;
    logic [2:0]    entry_index;
    logic [CW-1:0] scan_off;
    logic [AW-1:0] scan_pos;
    logic [AW-1:0] len_pos;
    logic [7:0]    hbyte;
    logic [AW:0]   pos_diff;
    logic [16:0]   need_sum;
    logic [FIW-1:0] tab_idx;

    brhs_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready    = (state_reg == S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign req         = s_tuser;
    assign byte_in     = s_tdata[7:0];
    assign entry_index = s_tdata[10:8];
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;

    assign scan_off = scan_reg + CW'(hidx_reg);
    assign scan_pos = wrap(CW'(head_reg), scan_off);
    assign len_pos  = wrap(CW'(last_pos_reg), CW'(lofs_reg));
    assign hbyte    = (32'(hidx_reg) < HDR_MAX) ? hdr_reg[8*hidx_reg +: 8] : 8'd0;
    assign need_sum = 17'(hsize_reg) + 17'd2 + {1'b0, len_hi_reg, len_lo_reg};
    assign tab_idx  = FIW'(entry_index);

    always_comb begin
        pos_diff = {1'b0, wrap(CW'(head_reg), scan_reg)} - {1'b0, last_pos_reg};
        if (pos_diff[AW]) begin
            pos_diff = pos_diff + (AW+1)'(DEPTH);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = byte_in;
        mem_raddr = head_reg;
        case (state_reg)
            S_IDLE: begin
                mem_we = accept && (req == REQ_PUSH);
            end
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'd0;
            end
            S_POP: begin
                mem_we    = 1'b1;
                mem_waddr = head_reg;
                mem_wdata = 8'd0;
            end
            S_SRD:  mem_raddr = scan_pos;
            S_LEN0: mem_raddr = len_pos;
            S_LEN1: mem_raddr = wrap(CW'(len_pos), CW'(1));
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        never_next    = never_reg;
        found_next    = found_reg;
        heavy_next    = heavy_reg;
        clr_addr_next = clr_addr_reg;
        clr_req_next  = clr_req_reg;
        scan_next     = scan_reg;
        hidx_next     = hidx_reg;
        last_pos_next = last_pos_reg;
        len_lo_next   = len_lo_reg;
        len_hi_next   = len_hi_reg;
        pos_tab_next  = pos_tab_reg;
        dist_tab_next = dist_tab_reg;
        res_ok_next   = res_ok_reg;
        res_byte_next = res_byte_reg;
        res_stat_next = res_stat_reg;
        res_pos_next  = res_pos_reg;
        res_dist_next = res_dist_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_ok_next   = 1'b0;
                    res_byte_next = 8'd0;
                    res_stat_next = ST_EMPTY;
                    res_pos_next  = 8'd0;
                    res_dist_next = 16'd0;
                    state_next    = S_DONE;
                    case (req)
                        REQ_PUSH: begin
                            never_next    = 1'b0;
                            tail_next     = wrap(CW'(tail_reg), CW'(1));
                            if (count_reg == CW'(DEPTH)) begin
                                head_next = wrap(CW'(head_reg), CW'(1));
                            end else begin
                                count_next = count_reg + CW'(1);
                            end
                            res_ok_next   = 1'b1;
                            res_stat_next = ST_OK;
                        end
                        REQ_POP: begin
                            if (count_reg != '0) begin
                                state_next = S_POP;
                            end
                        end
                        REQ_SEARCH: state_next = S_CHK;
                        REQ_READ: begin
                            if (32'(entry_index) < MAX_FOUND
                                    && 32'(entry_index) < 32'(found_reg)) begin
                                res_ok_next   = 1'b1;
                                res_stat_next = ST_OK;
                                res_pos_next  = 8'(pos_tab_reg[tab_idx]);
                                res_dist_next = dist_tab_reg[tab_idx];
                            end
                        end
                        REQ_CLEAR: begin
                            head_next     = '0;
                            tail_next     = '0;
                            count_next    = '0;
                            never_next    = 1'b1;
                            found_next    = '0;
                            heavy_next    = 1'b0;
                            clr_addr_next = '0;
                            clr_req_next  = 1'b1;
                            res_ok_next   = 1'b1;
                            res_stat_next = ST_OK;
                            state_next    = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = clr_req_reg ? S_DONE : S_IDLE;
                end
            end
            S_POP: begin
                res_ok_next   = 1'b1;
                res_stat_next = ST_OK;
                res_byte_next = mem_rdata;
                head_next     = wrap(CW'(head_reg), CW'(1));
                count_next    = count_reg - CW'(1);
                state_next    = S_DONE;
            end
            S_CHK: begin
                state_next = S_DONE;
                if (hsize_reg <= 3'd1) begin
                    res_stat_next = ST_HDR_SMALL;
                end else if (32'(hsize_reg) > HDR_MAX) begin
                    res_stat_next = ST_HDR_LARGE;
                end else if (never_reg) begin
                    res_stat_next = ST_NEVER_PUSH;
                end else if (32'(count_reg) < 32'(hsize_reg) + 2) begin
                    res_stat_next = ST_FEW_BYTES;
                end else if (lofs_reg < hsize_reg
                        || {1'b0, lofs_reg} >= {1'b0, hsize_reg} + 4'd2) begin
                    res_stat_next = ST_LEN_OFS;
                end else if (lwid_reg > 2'd2) begin
                    res_stat_next = ST_LEN_WIDTH;
                end else begin
                    res_ok_next   = 1'b1;
                    res_stat_next = ST_OK;
                    found_next    = '0;
                    heavy_next    = 1'b0;
                    scan_next     = '0;
                    hidx_next     = '0;
                    state_next    = S_SRD;
                end
            end
            S_SRD: begin
                if (32'(scan_reg) + 32'(hsize_reg) > 32'(count_reg)) begin
                    state_next = (found_reg == '0) ? S_DONE : S_LEN0;
                end else begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                state_next = S_SRD;
                if (mem_rdata != hbyte) begin
                    scan_next = scan_reg + CW'(1);
                    hidx_next = '0;
                end else if (hidx_reg == hsize_reg - 3'd1) begin
                    scan_next = scan_reg + CW'(1);
                    hidx_next = '0;
                    if (32'(found_reg) < MAX_FOUND) begin
                        pos_tab_next[FIW'(found_reg)]  = wrap(CW'(head_reg), scan_reg);
                        dist_tab_next[FIW'(found_reg)] = 16'd0;
                        if (found_reg != '0) begin
                            dist_tab_next[FIW'(found_reg - FCW'(1))] = 16'(pos_diff);
                        end
                        last_pos_next = wrap(CW'(head_reg), scan_reg);
                        found_next    = found_reg + FCW'(1);
                    end else begin
                        heavy_next = 1'b1;
                    end
                end else begin
                    hidx_next = hidx_reg + 3'd1;
                end
            end
            S_LEN0: state_next = S_LEN1;
            S_LEN1: begin
                len_lo_next = mem_rdata;
                len_hi_next = 8'd0;
                state_next  = (lwid_reg == 2'd1) ? S_NEED : S_LEN2;
            end
            S_LEN2: begin
                len_hi_next = mem_rdata;
                state_next  = S_NEED;
            end
            S_NEED: begin
                if (17'(count_reg) >= {1'b0, need_sum[15:0]}) begin
                    dist_tab_next[FIW'(found_reg - FCW'(1))] = need_sum[15:0];
                end else begin
                    found_next = found_reg - FCW'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, 9'(count_reg), heavy_reg, res_dist_reg,
                                    res_pos_reg, 4'(found_reg), res_stat_reg,
                                    res_byte_reg, res_ok_reg};
                    clr_req_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg      <= '0;
            hsize_reg    <= 3'd2;
            lofs_reg     <= 3'd2;
            lwid_reg     <= 2'd1;
            state_reg    <= S_CLR;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            never_reg    <= 1'b1;
            found_reg    <= '0;
            heavy_reg    <= 1'b0;
            clr_addr_reg <= '0;
            clr_req_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HDR_BYTES: hdr_reg   <= cfg_data;
                    CFG_HDR_SIZE:  hsize_reg <= cfg_data[2:0];
                    CFG_LEN_OFS:   lofs_reg  <= cfg_data[2:0];
                    CFG_LEN_WIDTH: lwid_reg  <= cfg_data[1:0];
                    default: ;
                endcase
            end
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            never_reg    <= never_next;
            found_reg    <= found_next;
            heavy_reg    <= heavy_next;
            clr_addr_reg <= clr_addr_next;
            clr_req_reg  <= clr_req_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg     <= scan_next;
        hidx_reg     <= hidx_next;
        last_pos_reg <= last_pos_next;
        len_lo_reg   <= len_lo_next;
        len_hi_reg   <= len_hi_next;
        pos_tab_reg  <= pos_tab_next;
        dist_tab_reg <= dist_tab_next;
        res_ok_reg   <= res_ok_next;
        res_byte_reg <= res_byte_next;
        res_stat_reg <= res_stat_next;
        res_pos_reg  <= res_pos_next;
        res_dist_reg <= res_dist_next;
        m_data_reg   <= m_data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/brhs_checker.sv =====
// brhs_checker: port-level checks on the byte ring with header search, and its bind
// depends on brhs_pkg
`timescale 1ns / 1ps
`default_nettype none
module brhs_checker
    import brhs_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // ok and status agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[11:9] == ST_OK)))
        else $error("ok flag and status disagree");

    // a popped byte only comes with success
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[8:1] != 8'd0) |-> m_tdata[0])
        else $error("byte out on failed transaction");

endmodule

bind byte_ring_with_header_search brhs_checker u_brhs_checker (.*);
`default_nettype wire

// ===== tb/sv/ring_search_checker.sv =====
// ring_search_checker: watches the request, result and register ports of the byte ring
// keeps its own copy of the ring and the found-header table and compares every result
// depends on brhs_pkg
`timescale 1ns / 1ps
module ring_search_checker
    import brhs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]             s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_index,
    input  logic [HDR_BITS-1:0]    cfg_data,
    output int                     pending,
    output int                     failures
);

    typedef struct packed {
        logic        ok;
        logic [7:0]  byte_out;
        logic [2:0]  status;
        logic [3:0]  found_count;
        logic [7:0]  entry_position;
        logic [15:0] entry_distance;
        logic        heavy;
        logic [8:0]  stored_count;
    } response_t;

    logic [7:0]          ring_bytes [256];
    int                  head_ptr;
    int                  tail_ptr;
    int                  held;
    bit                  untouched;
    logic [7:0]          found_pos [8];
    logic [15:0]         found_dist [8];
    int                  found_num;
    bit                  heavy_seen;
    logic [HDR_BITS-1:0] hdr_pattern;
    int                  hdr_len;
    int                  len_ofs;
    int                  len_mode;
    response_t           expected_q [$];

    function automatic void wipe_ring();
        for (int i = 0; i < 256; i++) ring_bytes[i] = 8'd0;
        for (int i = 0; i < 8; i++) begin
            found_pos[i] = 8'd0;
            found_dist[i] = 16'd0;
        end
        head_ptr = 0;
        tail_ptr = 0;
        held = 0;
        untouched = 1;
        found_num = 0;
        heavy_seen = 0;
    endfunction

    function automatic logic [2:0] header_scan();
        bit hit;
        int last;
        int p;
        int len;
        int need;
        if (hdr_len <= 1) return ST_HDR_SMALL;
        if (hdr_len > HDR_MAX) return ST_HDR_LARGE;
        if (untouched) return ST_NEVER_PUSH;
        if (held < hdr_len + 2) return ST_FEW_BYTES;
        if (len_ofs < hdr_len || len_ofs >= hdr_len + 2) return ST_LEN_OFS;
        if (len_mode > 2) return ST_LEN_WIDTH;
        found_num = 0;
        heavy_seen = 0;
        for (int s = 0; s + hdr_len <= held; s++) begin
            hit = 1;
            for (int i = 0; i < hdr_len; i++)
                if (ring_bytes[(head_ptr + s + i) % 256] != hdr_pattern[8*i +: 8]) hit = 0;
            if (hit) begin
                if (found_num < 8) begin
                    found_pos[found_num] = 8'((head_ptr + s) % 256);
                    found_dist[found_num] = 16'd0;
                    found_num++;
                end else begin
                    heavy_seen = 1;
                end
            end
        end
        if (found_num == 0) return ST_OK;
        for (int i = 0; i + 1 < found_num; i++)
            found_dist[i] = 16'((int'(found_pos[i+1]) + 256 - int'(found_pos[i])) % 256);
        last = found_num - 1;
        p = (int'(found_pos[last]) + len_ofs) % 256;
        len = ring_bytes[p];
        if (len_mode != 1) len = len | (int'(ring_bytes[(p + 1) % 256]) << 8);
        need = (hdr_len + 2 + len) & 16'hFFFF;
        if (held >= need) found_dist[last] = 16'(need);
        else found_num--;
        return ST_OK;
    endfunction

    function automatic response_t compute_response(logic [2:0] req, logic [7:0] din,
                                                   logic [2:0] idx);
        response_t r;
        r = '0;
        r.status = ST_EMPTY;
        case (req)
            REQ_PUSH: begin
                untouched = 0;
                ring_bytes[tail_ptr] = din;
                tail_ptr = (tail_ptr + 1) % 256;
                held++;
                if (held > 256) begin
                    held = 256;
                    head_ptr = (head_ptr + 1) % 256;
                end
                r.ok = 1;
                r.status = ST_OK;
            end
            REQ_POP: begin
                if (held > 0) begin
                    r.byte_out = ring_bytes[head_ptr];
                    ring_bytes[head_ptr] = 8'd0;
                    head_ptr = (head_ptr + 1) % 256;
                    held--;
                    r.ok = 1;
                    r.status = ST_OK;
                end
            end
            REQ_SEARCH: begin
                r.status = header_scan();
                r.ok = (r.status == ST_OK);
            end
            REQ_READ: begin
                if (idx < found_num) begin
                    r.entry_position = found_pos[idx];
                    r.entry_distance = found_dist[idx];
                    r.ok = 1;
                    r.status = ST_OK;
                end
            end
            REQ_CLEAR: begin
                wipe_ring();
                r.ok = 1;
                r.status = ST_OK;
            end
            default: ;
        endcase
        r.found_count = 4'(found_num);
        r.heavy = heavy_seen;
        r.stored_count = 9'(held);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    initial failures = 0;

    always @(posedge aclk) begin
        response_t want;
        if (!aresetn) begin
            hdr_pattern = '0;
            hdr_len = 2;
            len_ofs = 2;
            len_mode = 1;
            wipe_ring();
            expected_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_HDR_BYTES: hdr_pattern = cfg_data;
                    CFG_HDR_SIZE:  hdr_len = cfg_data[2:0];
                    CFG_LEN_OFS:   len_ofs = cfg_data[2:0];
                    CFG_LEN_WIDTH: len_mode = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(compute_response(s_tuser, s_tdata[7:0], s_tdata[10:8]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    failures++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("ok", want.ok, m_tdata[0]);
                    check_field("byte_out", want.byte_out, m_tdata[8:1]);
                    check_field("status", want.status, m_tdata[11:9]);
                    check_field("found_count", want.found_count, m_tdata[15:12]);
                    check_field("entry_position", want.entry_position, m_tdata[23:16]);
                    check_field("entry_distance", want.entry_distance, m_tdata[39:24]);
                    check_field("heavy", want.heavy, m_tdata[40]);
                    check_field("stored_count", want.stored_count, m_tdata[49:41]);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== tb/sv/tb_byte_ring_with_header_search.sv =====
// tb_byte_ring_with_header_search: stimulus, handshake pacing and verdict for the byte ring
// depends on brhs_pkg, byte_ring_with_header_search and ring_search_checker
`timescale 1ns / 1ps
module tb_byte_ring_with_header_search;
    import brhs_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [2:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en;
    logic [1:0]             cfg_index;
    logic [HDR_BITS-1:0]    cfg_data;
    int                     pending;
    int                     failures;
    int                     cycles = 0;
    int                     sent;
    int                     stall_left;
    bit                     quiet;
    logic [HDR_BITS-1:0]    cur_hdr;
    int                     cur_hsize;
    int                     cur_lofs;
    int                     cur_lwidth;

    byte_ring_with_header_search uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ring_search_checker ring_monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .failures(failures)
    );

    initial aclk = 0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("byte_ring_with_header_search regression: fail");
            $finish;
        end
    end

    function automatic int idle_cycles();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    // result side stall, drawn per transaction
    always @(posedge aclk) begin
        int n;
        if (!aresetn) begin
            m_tready <= 0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            n = idle_cycles();
            m_tready <= (n == 0);
            stall_left <= n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else begin
            m_tready <= 1;
        end
    end

    task automatic send(input logic [2:0] req, input logic [7:0] b, input logic [2:0] idx);
        int gap;
        bit taken;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= {5'd0, idx, b};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        do @(negedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic put_cfg(input logic [HDR_BITS-1:0] hb, input int hs, input int lo,
                           input int lw);
        wait_drained();
        cfg_wr_en <= 1;
        cfg_index <= CFG_HDR_BYTES;
        cfg_data <= hb;
        @(posedge aclk);
        cfg_index <= CFG_HDR_SIZE;
        cfg_data <= HDR_BITS'(hs);
        @(posedge aclk);
        cfg_index <= CFG_LEN_OFS;
        cfg_data <= HDR_BITS'(lo);
        @(posedge aclk);
        cfg_index <= CFG_LEN_WIDTH;
        cfg_data <= HDR_BITS'(lw);
        @(posedge aclk);
        cfg_wr_en <= 0;
        cur_hdr = hb;
        cur_hsize = hs;
        cur_lofs = lo;
        cur_lwidth = lw;
    endtask

    // header, optional filler up to the length field, length, then payload
    task automatic push_packet();
        int len;
        int body;
        for (int i = 0; i < cur_hsize && i < HDR_MAX; i++)
            send(REQ_PUSH, cur_hdr[8*i +: 8], 3'($urandom));
        if (cur_lofs > cur_hsize) send(REQ_PUSH, 8'($urandom), 3'($urandom));
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 65535);
        if (cur_lwidth == 1) begin
            len = len & 8'hFF;
            send(REQ_PUSH, 8'(len), 3'($urandom));
        end else begin
            send(REQ_PUSH, 8'(len), 3'($urandom));
            send(REQ_PUSH, 8'(len >> 8), 3'($urandom));
        end
        body = (len <= 16) ? len : $urandom_range(0, 16);
        repeat (body) send(REQ_PUSH, 8'($urandom), 3'($urandom));
    endtask

    task automatic random_items(input int n, input bit clear_ok);
        int target;
        int r;
        target = sent + n;
        while (sent < target) begin
            if ($urandom_range(0, 39) == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 30) push_packet();
            else if (r < 55) send(REQ_PUSH, 8'($urandom), 3'($urandom));
            else if (r < 65) send(REQ_POP, 8'($urandom), 3'($urandom));
            else if (r < 77) send(REQ_SEARCH, 8'($urandom), 3'($urandom));
            else if (r < 92) send(REQ_READ, 8'($urandom), 3'($urandom));
            else if (r < 95 && clear_ok) send(REQ_CLEAR, 8'($urandom), 3'($urandom));
            else if (r < 95) send(REQ_SEARCH, 8'($urandom), 3'($urandom));
            else send(3'($urandom_range(5, 7)), 8'($urandom), 3'($urandom));
        end
    endtask

    initial begin
        sent = 0;
        quiet = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = REQ_PUSH;
        cfg_wr_en = 0;
        cfg_index = CFG_HDR_BYTES;
        cfg_data = '0;
        cur_hdr = '0;
        cur_hsize = 2;
        cur_lofs = 2;
        cur_lwidth = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // error paths and edge values, first under reset settings, then under bad configurations
        send(REQ_SEARCH, 8'h00, 3'd0);
        send(REQ_POP, 8'h00, 3'd0);
        send(REQ_READ, 8'h00, 3'd0);
        send(3'd5, 8'h00, 3'd0);
        send(3'd6, 8'h00, 3'd0);
        send(3'd7, 8'hFF, 3'd7);
        send(REQ_PUSH, 8'hFF, 3'd7);
        send(REQ_PUSH, 8'h00, 3'd0);
        send(REQ_SEARCH, 8'h00, 3'd0);
        repeat (6) send(REQ_PUSH, 8'h00, 3'd0);
        send(REQ_SEARCH, 8'h00, 3'd0);
        send(REQ_READ, 8'h00, 3'd0);
        send(REQ_READ, 8'h00, 3'd7);
        send(REQ_POP, 8'h00, 3'd0);
        put_cfg('0, 0, 2, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 1, 2, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 6, 6, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 7, 7, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 3, 2, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 3, 0, 1);
        send(REQ_SEARCH, 8'h00, 3'd0);
        put_cfg('0, 2, 3, 3);
        send(REQ_SEARCH, 8'h00, 3'd0);
        send(REQ_CLEAR, 8'h00, 3'd0);

        put_cfg(40'h00_0000_55AA, 2, 3, 0);
        random_items(40, 1);
        // long run without clears so the ring wraps and overwrites
        repeat (30) push_packet();
        repeat (6) send(REQ_SEARCH, 8'h00, 3'd0);
        for (int i = 0; i < 8; i++) send(REQ_READ, 8'h00, 3'(i));
        put_cfg({$urandom, 8'($urandom)}, 5, 5, 1);
        random_items(40, 1);
        put_cfg({$urandom, 8'($urandom)}, 5, 6, 2);
        random_items(40, 1);
        put_cfg({HDR_BITS{1'b1}}, 3, 3, 1);
        random_items(40, 1);
        put_cfg({$urandom, 8'($urandom)}, 4, 5, 0);
        random_items(40, 1);
        put_cfg(40'h00_0000_0000, 2, 2, 1);
        random_items(40, 0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("byte_ring_with_header_search regression: pass");
        else
            $display("byte_ring_with_header_search regression: fail");
        $finish;
    end

endmodule
